[src/tpca_pkg.sv]
// Shared widths, types, register codes and the arctangent table for the curvature core.
package tpca_pkg;

  // Field widths
  localparam int COORD_W        = 32;
  localparam int EDGE_W         = COORD_W + 1;
  localparam int SQ_W           = 2 * EDGE_W;
  localparam int HALF_W         = EDGE_W;
  localparam int AB_W           = 2 * SQ_W;
  localparam int SUM_W          = AB_W + HALF_W;
  localparam int PROD_W         = 3 * SQ_W;
  localparam int ROOT_W         = PROD_W / 2;
  localparam int PREM_W         = ROOT_W + 2;
  localparam int CROOT_W        = SQ_W / 2;
  localparam int CREM_W         = CROOT_W + 2;
  localparam int RATIO_W        = 16;
  localparam int ARC_CURV_W     = 20;
  localparam int CURV_FRAC_BITS = 24;
  localparam int CURV_W         = 40;
  localparam int KMAG_W         = CURV_W - 1;
  localparam int PATH_W         = 48;

  // Angle unit
  localparam int ANG_IN_W       = 29;
  localparam int ANG_W          = 34;
  localparam int Z_W            = 32;
  localparam int CORDIC_STEPS   = 30;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // Curvature divider: round(|cross| * 2^(17+F) / S)
  localparam int CRV_SHIFT      = 17 + CURV_FRAC_BITS + 1;
  localparam int D1_N_W         = SQ_W + CRV_SHIFT + 1;
  localparam int D1_D_W         = ROOT_W + 1;
  localparam int D1_Q_W         = KMAG_W + 1;

  // Arc divider: round(z * 2^(F+17) / (k * 2^30))
  localparam int ARC_SHIFT      = CURV_FRAC_BITS + 17 - 30 + 1;
  localparam int D2_N_W         = Z_W + ARC_SHIFT + 1;
  localparam int D2_D_W         = KMAG_W + 1;
  localparam int D2_Q_W         = D2_N_W;

  // Pipeline depth
  localparam int FRONT_STAGES   = 8;
  localparam int MID_STAGES     = ROOT_W;
  localparam int D1_STAGES      = D1_Q_W + 1;
  localparam int D2_STAGES      = D2_Q_W + 1;
  localparam int LAT            = FRONT_STAGES + MID_STAGES + D1_STAGES + D2_STAGES + 1;

  // Register map (word index)
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_MIN_SQ_EDGE  = 2'd0;
  localparam logic [1:0] REG_RATIO_LIMIT  = 2'd1;
  localparam logic [1:0] REG_MIN_ARC_CURV = 2'd2;
  localparam logic [1:0] REG_ARC_MODE     = 2'd3;

  // Root, chord root and angle state carried through the long middle section
  typedef struct packed {
    logic [PROD_W-1:0]       prad;
    logic [PREM_W-1:0]       prem;
    logic [ROOT_W-1:0]       proot;
    logic [SQ_W-1:0]         crad;
    logic [CREM_W-1:0]       crem;
    logic [CROOT_W:0]        croot;
    logic [SQ_W-1:0]         nx;
    logic [SQ_W-1:0]         ny;
    logic                    dneg;
    logic signed [ANG_W-1:0] rx;
    logic signed [ANG_W-1:0] ry;
    logic signed [ANG_W-1:0] rz;
    logic [SQ_W-1:0]         crs_m;
    logic                    crs_neg;
    logic                    degen;
  } mid_t;

  typedef struct packed {
    logic [D1_N_W-1:0] n;
    logic [D1_D_W-1:0] d;
    logic [D1_D_W-1:0] rem;
    logic [D1_Q_W-1:0] q;
    logic              ovf;
    logic              crs_neg;
    logic              degen;
    logic [CROOT_W:0]  chord;
    logic [Z_W-1:0]    z;
  } d1_t;

  typedef struct packed {
    logic [D2_N_W-1:0] n;
    logic [D2_D_W-1:0] d;
    logic [D2_D_W-1:0] rem;
    logic [D2_Q_W-1:0] q;
    logic              use_arc;
    logic              degen;
    logic [CURV_W-1:0] curv;
    logic [CROOT_W:0]  chord;
  } d2_t;

  // atan(2^-i) in Q.30, truncated
  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd7;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/three_point_curvature_arc_core.sv]
// Signed three-point curvature and arc/chord path length, fully pipelined.
//
// Input channel: one beat carries three points (first, mid, last), signed Q15.16.
// Output channel: one beat carries curvature (Q15.24, positive for a left turn),
// path length (Q32.16) and the degenerate flag.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// One beat is accepted every cycle unless the output beat is stalled. The depth
// is 8 front-end stages, the 99-stage square root of A*B*C, a 41-stage curvature
// divider, a 46-stage arc divider and the output register; the chord root and
// the 30-step CORDIC angle unit run alongside the long root.
// While the output beat is stalled the whole pipeline holds and in_stall_o is
// high; nothing is dropped or repeated.
// Configuration goes through the APB port (word addresses 0..3): min_sq_edge,
// ratio_limit, min_arc_curvature, arc_mode. Write it only while the core is idle.
// Reset clears the pipeline valid bits and loads the register defaults
// (4295, 10000, 0, 1).
module three_point_curvature_arc_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tpca_pkg::COORD_W-1:0] first_x_i,
  input  logic signed [tpca_pkg::COORD_W-1:0] first_y_i,
  input  logic signed [tpca_pkg::COORD_W-1:0] mid_x_i,
  input  logic signed [tpca_pkg::COORD_W-1:0] mid_y_i,
  input  logic signed [tpca_pkg::COORD_W-1:0] last_x_i,
  input  logic signed [tpca_pkg::COORD_W-1:0] last_y_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tpca_pkg::CURV_W-1:0]  curvature_out_o,
  output logic [tpca_pkg::PATH_W-1:0]         path_length_o,
  output logic                                degenerate_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tpca_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int EW = tpca_pkg::EDGE_W;
  localparam int SW = tpca_pkg::SQ_W;
  localparam int HW = tpca_pkg::HALF_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [31:0]                       min_sq_edge_q;
  logic [tpca_pkg::RATIO_W-1:0]      ratio_limit_q;
  logic [tpca_pkg::ARC_CURV_W-1:0]   min_arc_curv_q;
  logic                              arc_mode_q;
  logic                              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sq_edge_q  <= 32'd4295;
      ratio_limit_q  <= 16'd10000;
      min_arc_curv_q <= '0;
      arc_mode_q     <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tpca_pkg::REG_MIN_SQ_EDGE:  min_sq_edge_q  <= pwdata;
        tpca_pkg::REG_RATIO_LIMIT:  ratio_limit_q  <= pwdata[tpca_pkg::RATIO_W-1:0];
        tpca_pkg::REG_MIN_ARC_CURV: min_arc_curv_q <= pwdata[tpca_pkg::ARC_CURV_W-1:0];
        tpca_pkg::REG_ARC_MODE:     arc_mode_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      tpca_pkg::REG_MIN_SQ_EDGE:  prdata = min_sq_edge_q;
      tpca_pkg::REG_RATIO_LIMIT:  prdata = 32'(ratio_limit_q);
      tpca_pkg::REG_MIN_ARC_CURV: prdata = 32'(min_arc_curv_q);
      tpca_pkg::REG_ARC_MODE:     prdata = 32'(arc_mode_q);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Valid chain and global advance
  logic [tpca_pkg::LAT-1:0] vld_q;
  logic                     adv;

  assign adv         = ~(vld_q[tpca_pkg::LAT-1] & out_stall_i);
  assign in_stall_o  = ~adv;
  assign out_valid_o = vld_q[tpca_pkg::LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[tpca_pkg::LAT-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: edge vectors
  logic signed [EW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q <= EW'(mid_x_i) - EW'(first_x_i);
      ay_q <= EW'(mid_y_i) - EW'(first_y_i);
      bx_q <= EW'(last_x_i) - EW'(mid_x_i);
      by_q <= EW'(last_y_i) - EW'(mid_y_i);
      cx_q <= EW'(first_x_i) - EW'(last_x_i);
      cy_q <= EW'(first_y_i) - EW'(last_y_i);
    end
  end

  // Stage 2: squares of all edge components and the a-b cross terms
  logic signed [SW-1:0] sq_ax_q, sq_ay_q, sq_bx_q, sq_by_q, sq_cx_q, sq_cy_q;
  logic signed [SW-1:0] p_axby_q, p_aybx_q, p_axbx_q, p_ayby_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_ax_q  <= ax_q * ax_q;
      sq_ay_q  <= ay_q * ay_q;
      sq_bx_q  <= bx_q * bx_q;
      sq_by_q  <= by_q * by_q;
      sq_cx_q  <= cx_q * cx_q;
      sq_cy_q  <= cy_q * cy_q;
      p_axby_q <= ax_q * by_q;
      p_aybx_q <= ay_q * bx_q;
      p_axbx_q <= ax_q * bx_q;
      p_ayby_q <= ay_q * by_q;
    end
  end

  // Stage 3: squared lengths, cross and dot
  logic [SW-1:0]        a3_q, b3_q, c3_q;
  logic signed [SW:0]   crs3_q, dot3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a3_q   <= $unsigned(sq_ax_q) + $unsigned(sq_ay_q);
      b3_q   <= $unsigned(sq_bx_q) + $unsigned(sq_by_q);
      c3_q   <= $unsigned(sq_cx_q) + $unsigned(sq_cy_q);
      crs3_q <= (SW+1)'(p_axby_q) - (SW+1)'(p_aybx_q);
      dot3_q <= (SW+1)'(p_axbx_q) + (SW+1)'(p_ayby_q);
    end
  end

  // Stage 4: min/max, magnitudes, A*B partial products
  logic [SW-1:0] lo4_q, hi4_q, c4_q, crsm4_q, dotm4_q;
  logic          crsn4_q, dotn4_q;
  logic [SW-1:0] pp_ab_q [4];
  logic [SW-1:0] lo4_d, hi4_d;

  always_comb begin
    lo4_d = a3_q;
    hi4_d = a3_q;
    if (b3_q < lo4_d) lo4_d = b3_q;
    if (c3_q < lo4_d) lo4_d = c3_q;
    if (b3_q > hi4_d) hi4_d = b3_q;
    if (c3_q > hi4_d) hi4_d = c3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo4_q      <= lo4_d;
      hi4_q      <= hi4_d;
      c4_q       <= c3_q;
      crsn4_q    <= crs3_q[SW];
      crsm4_q    <= crs3_q[SW] ? SW'(-crs3_q) : crs3_q[SW-1:0];
      dotn4_q    <= dot3_q[SW];
      dotm4_q    <= dot3_q[SW] ? SW'(-dot3_q) : dot3_q[SW-1:0];
      pp_ab_q[0] <= a3_q[HW-1:0]  * b3_q[HW-1:0];
      pp_ab_q[1] <= a3_q[HW-1:0]  * b3_q[SW-1:HW];
      pp_ab_q[2] <= a3_q[SW-1:HW] * b3_q[HW-1:0];
      pp_ab_q[3] <= a3_q[SW-1:HW] * b3_q[SW-1:HW];
    end
  end

  // Stage 5: A*B sum, ratio_limit*min
  localparam int RLT_W = tpca_pkg::RATIO_W + SW;
  logic [tpca_pkg::AB_W-1:0] ab5_q;
  logic [RLT_W-1:0]          rlt5_q;
  logic [SW-1:0]             lo5_q, hi5_q, c5_q, crsm5_q, dotm5_q;
  logic                      crsn5_q, dotn5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ab5_q   <= tpca_pkg::AB_W'(pp_ab_q[0])
               + (tpca_pkg::AB_W'(pp_ab_q[1]) << HW)
               + (tpca_pkg::AB_W'(pp_ab_q[2]) << HW)
               + (tpca_pkg::AB_W'(pp_ab_q[3]) << (2 * HW));
      rlt5_q  <= RLT_W'(ratio_limit_q) * RLT_W'(lo4_q);
      lo5_q   <= lo4_q;
      hi5_q   <= hi4_q;
      c5_q    <= c4_q;
      crsm5_q <= crsm4_q;
      crsn5_q <= crsn4_q;
      dotm5_q <= dotm4_q;
      dotn5_q <= dotn4_q;
    end
  end

  // Stage 6: degenerate test, (A*B)*C partial products
  logic [SW-1:0] pp_abc_q [8];
  logic [SW-1:0] c6_q, crsm6_q, dotm6_q;
  logic          crsn6_q, dotn6_q, degen6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      degen6_q <= (lo5_q == '0) || (lo5_q < SW'(min_sq_edge_q)) || (rlt5_q < RLT_W'(hi5_q));
      c6_q     <= c5_q;
      crsm6_q  <= crsm5_q;
      crsn6_q  <= crsn5_q;
      dotm6_q  <= dotm5_q;
      dotn6_q  <= dotn5_q;
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_abc
    for (genvar k = 0; k < 2; k++) begin : g_abc_k
      always_ff @(posedge clk_i) begin
        if (adv) begin
          pp_abc_q[j*2+k] <= ab5_q[HW*j +: HW] * c5_q[HW*k +: HW];
        end
      end
    end
  end

  // Stage 7: two column sums of the product
  localparam int SUMW = tpca_pkg::SUM_W;
  logic [SUMW-1:0] sum0_q, sum1_q;
  logic [SW-1:0]   c7_q, crsm7_q, dotm7_q;
  logic            crsn7_q, dotn7_q, degen7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum0_q   <= SUMW'(pp_abc_q[0]) + (SUMW'(pp_abc_q[2]) << HW)
                + (SUMW'(pp_abc_q[4]) << (2 * HW)) + (SUMW'(pp_abc_q[6]) << (3 * HW));
      sum1_q   <= SUMW'(pp_abc_q[1]) + (SUMW'(pp_abc_q[3]) << HW)
                + (SUMW'(pp_abc_q[5]) << (2 * HW)) + (SUMW'(pp_abc_q[7]) << (3 * HW));
      c7_q     <= c6_q;
      crsm7_q  <= crsm6_q;
      crsn7_q  <= crsn6_q;
      dotm7_q  <= dotm6_q;
      dotn7_q  <= dotn6_q;
      degen7_q <= degen6_q;
    end
  end

  // Stage 8: full product A*B*C, load the middle section
  tpca_pkg::mid_t mid0_d, mid0_q;

  always_comb begin
    mid0_d         = '0;
    mid0_d.prad    = tpca_pkg::PROD_W'(sum0_q) + (tpca_pkg::PROD_W'(sum1_q) << HW);
    mid0_d.crad    = c7_q;
    mid0_d.nx      = dotm7_q;
    mid0_d.ny      = crsm7_q;
    mid0_d.dneg    = dotn7_q;
    mid0_d.crs_m   = crsm7_q;
    mid0_d.crs_neg = crsn7_q;
    mid0_d.degen   = degen7_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) mid0_q <= mid0_d;
  end

  // ---------------------------------------------------------------------------
  // Middle section: one bit of sqrt(A*B*C) per stage; alongside it the chord
  // root (rounded), the angle normalize, pre-rotation, CORDIC and clamp.
  localparam int MS = tpca_pkg::MID_STAGES;
  tpca_pkg::mid_t mid_q   [1:MS];
  tpca_pkg::mid_t mid_src [0:MS-1];

  for (genvar k = 0; k < MS; k++) begin : g_mid
    tpca_pkg::mid_t nxt;

    if (k == 0) begin : g_src0
      assign mid_src[k] = mid0_q;
    end else begin : g_srcn
      assign mid_src[k] = mid_q[k];
    end

    always_comb begin
      tpca_pkg::mid_t            s;
      logic [tpca_pkg::PREM_W+1:0] pt, ptr;
      logic [tpca_pkg::CREM_W+1:0] ct, ctr;
      logic [SW-1:0]               v;
      logic signed [tpca_pkg::ANG_W-1:0] dx, dy;
      logic [tpca_pkg::ANG_IN_W-1:0]     xm, ym;
      s   = mid_src[k];
      nxt = s;

      // product root, one bit
      pt       = {s.prem, s.prad[tpca_pkg::PROD_W-1 -: 2]};
      ptr      = {2'b00, s.proot, 2'b01};
      nxt.prad = {s.prad[tpca_pkg::PROD_W-3:0], 2'b00};
      if (pt >= ptr) begin
        nxt.prem  = tpca_pkg::PREM_W'(pt - ptr);
        nxt.proot = {s.proot[tpca_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        nxt.prem  = pt[tpca_pkg::PREM_W-1:0];
        nxt.proot = {s.proot[tpca_pkg::ROOT_W-2:0], 1'b0};
      end

      // chord root, then round to nearest
      ct  = {s.crem, s.crad[SW-1 -: 2]};
      ctr = {1'b0, s.croot, 2'b01};
      if (k < tpca_pkg::CROOT_W) begin
        nxt.crad = {s.crad[SW-3:0], 2'b00};
        if (ct >= ctr) begin
          nxt.crem  = tpca_pkg::CREM_W'(ct - ctr);
          nxt.croot = {s.croot[tpca_pkg::CROOT_W-1:0], 1'b1};
        end else begin
          nxt.crem  = ct[tpca_pkg::CREM_W-1:0];
          nxt.croot = {s.croot[tpca_pkg::CROOT_W-1:0], 1'b0};
        end
      end else if (k == tpca_pkg::CROOT_W) begin
        if (s.crem > tpca_pkg::CREM_W'(s.croot)) nxt.croot = s.croot + 1'b1;
      end

      // angle: normalize both magnitudes to 29 bits, two shift steps a stage
      v  = s.nx | s.ny;
      xm = s.nx[tpca_pkg::ANG_IN_W-1:0];
      ym = s.ny[tpca_pkg::ANG_IN_W-1:0];
      dx = s.ry >>> ((k >= 4 && k < 4 + tpca_pkg::CORDIC_STEPS) ? k - 4 : 0);
      dy = s.rx >>> ((k >= 4 && k < 4 + tpca_pkg::CORDIC_STEPS) ? k - 4 : 0);
      if (k < 3) begin
        // shift by s while at least 29+s bits are in use
        if ((v >> (tpca_pkg::ANG_IN_W - 1 + (32 >> (2 * k)))) != '0) begin
          nxt.nx = s.nx >> (32 >> (2 * k));
          nxt.ny = s.ny >> (32 >> (2 * k));
        end
        v = nxt.nx | nxt.ny;
        if ((v >> (tpca_pkg::ANG_IN_W - 1 + (16 >> (2 * k)))) != '0) begin
          nxt.nx = nxt.nx >> (16 >> (2 * k));
          nxt.ny = nxt.ny >> (16 >> (2 * k));
        end
      end else if (k == 3) begin
        // turn by -pi/2 when the dot product is negative
        if (s.dneg && (xm != '0)) begin
          nxt.rx = tpca_pkg::ANG_W'(ym);
          nxt.ry = tpca_pkg::ANG_W'(xm);
          nxt.rz = tpca_pkg::HALF_PI_Q30;
        end else begin
          nxt.rx = tpca_pkg::ANG_W'(xm);
          nxt.ry = tpca_pkg::ANG_W'(ym);
          nxt.rz = '0;
        end
      end else if (k < 4 + tpca_pkg::CORDIC_STEPS) begin
        // vectoring step
        if (s.ry > 0) begin
          nxt.rx = s.rx + dx;
          nxt.ry = s.ry - dy;
          nxt.rz = s.rz + tpca_pkg::atan_q30(k - 4);
        end else begin
          nxt.rx = s.rx - dx;
          nxt.ry = s.ry + dy;
          nxt.rz = s.rz - tpca_pkg::atan_q30(k - 4);
        end
      end else if (k == 4 + tpca_pkg::CORDIC_STEPS) begin
        if (s.rz < 0) nxt.rz = '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) mid_q[k+1] <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Curvature divider: q = floor((2N + S) / 2S), 40 quotient bits + overflow
  localparam int D1S = tpca_pkg::D1_Q_W;
  tpca_pkg::d1_t d1_q [0:D1S];
  tpca_pkg::d1_t d1_0_d;

  always_comb begin
    tpca_pkg::mid_t m;
    m               = mid_q[MS];
    d1_0_d.n        = (tpca_pkg::D1_N_W'(m.crs_m) << tpca_pkg::CRV_SHIFT)
                    + tpca_pkg::D1_N_W'(m.proot);
    d1_0_d.d        = {m.proot, 1'b0};
    d1_0_d.ovf      = (d1_0_d.n >> D1S) >= tpca_pkg::D1_N_W'(d1_0_d.d);
    d1_0_d.rem      = tpca_pkg::D1_D_W'(d1_0_d.n >> D1S);
    d1_0_d.q        = '0;
    d1_0_d.crs_neg  = m.crs_neg;
    d1_0_d.degen    = m.degen;
    d1_0_d.chord    = m.croot;
    d1_0_d.z        = m.rz[tpca_pkg::Z_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) d1_q[0] <= d1_0_d;
  end

  for (genvar i = 0; i < D1S; i++) begin : g_d1
    tpca_pkg::d1_t nxt;
    always_comb begin
      logic [tpca_pkg::D1_D_W:0] r2;
      nxt = d1_q[i];
      r2  = {d1_q[i].rem, d1_q[i].n[D1S-1-i]};
      if (r2 >= {1'b0, d1_q[i].d}) begin
        r2              = r2 - {1'b0, d1_q[i].d};
        nxt.q[D1S-1-i]  = 1'b1;
      end
      nxt.rem = r2[tpca_pkg::D1_D_W-1:0];
    end
    always_ff @(posedge clk_i) begin
      if (adv) d1_q[i+1] <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Saturate curvature, set up the arc divider: floor((2*z*2^11 + k) / 2k)
  localparam int D2S = tpca_pkg::D2_Q_W;
  tpca_pkg::d2_t d2_q [0:D2S];
  tpca_pkg::d2_t d2_0_d;

  always_comb begin
    tpca_pkg::d1_t                 r;
    logic [tpca_pkg::KMAG_W-1:0]   kmag;
    r    = d1_q[D1S];
    kmag = (r.ovf || r.q[D1S-1]) ? '1 : r.q[tpca_pkg::KMAG_W-1:0];
    d2_0_d.n       = (tpca_pkg::D2_N_W'(r.z) << tpca_pkg::ARC_SHIFT) + tpca_pkg::D2_N_W'(kmag);
    d2_0_d.d       = {kmag, 1'b0};
    d2_0_d.rem     = '0;
    d2_0_d.q       = '0;
    d2_0_d.use_arc = arc_mode_q && (kmag > tpca_pkg::KMAG_W'(min_arc_curv_q));
    d2_0_d.degen   = r.degen;
    d2_0_d.chord   = r.chord;
    if (r.degen) begin
      d2_0_d.curv = '0;
    end else if (r.crs_neg) begin
      d2_0_d.curv = -tpca_pkg::CURV_W'(kmag);
    end else begin
      d2_0_d.curv = tpca_pkg::CURV_W'(kmag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) d2_q[0] <= d2_0_d;
  end

  for (genvar i = 0; i < D2S; i++) begin : g_d2
    tpca_pkg::d2_t nxt;
    always_comb begin
      logic [tpca_pkg::D2_D_W:0] r2;
      nxt = d2_q[i];
      r2  = {d2_q[i].rem, d2_q[i].n[D2S-1-i]};
      if (r2 >= {1'b0, d2_q[i].d}) begin
        r2             = r2 - {1'b0, d2_q[i].d};
        nxt.q[D2S-1-i] = 1'b1;
      end
      nxt.rem = r2[tpca_pkg::D2_D_W-1:0];
    end
    always_ff @(posedge clk_i) begin
      if (adv) d2_q[i+1] <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: pick arc or chord
  logic signed [tpca_pkg::CURV_W-1:0] curv_q;
  logic [tpca_pkg::PATH_W-1:0]        path_q;
  logic                               degen_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      curv_q  <= d2_q[D2S].curv;
      degen_q <= d2_q[D2S].degen;
      if (d2_q[D2S].degen || !d2_q[D2S].use_arc) begin
        path_q <= tpca_pkg::PATH_W'(d2_q[D2S].chord);
      end else begin
        path_q <= tpca_pkg::PATH_W'(d2_q[D2S].q);
      end
    end
  end

  assign curvature_out_o = curv_q;
  assign path_length_o   = path_q;
  assign degenerate_o    = degen_q;

endmodule

[src/tpca_checker.sv]
// Port-level checks for the curvature core and the bind that attaches them.
module tpca_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [tpca_pkg::CURV_W-1:0] curvature_out_o,
  input logic [tpca_pkg::PATH_W-1:0]        path_length_o,
  input logic                               degenerate_o
);

  // a stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(curvature_out_o)
      && $stable(path_length_o) && $stable(degenerate_o))
    else $error("output beat changed while stalled");

  // input side only stalls when the output beat is held
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // a rejected triangle reports zero curvature
  a_degen_curv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> curvature_out_o == '0)
    else $error("degenerate beat with nonzero curvature");

  // a rejected triangle reports the chord, which never exceeds 34 bits
  a_degen_chord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> path_length_o[tpca_pkg::PATH_W-1:34] == '0)
    else $error("degenerate chord out of range");

endmodule

bind three_point_curvature_arc_core tpca_checker u_tpca_checker (.*);
